// ===== src/slice_axis_normalizer_assert.svh =====
// Assertion macros for the slice normalizer checker
`ifndef SLICE_AXIS_NORMALIZER_ASSERT_SVH
`define SLICE_AXIS_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SLAN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SLAN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slan_pkg.sv =====
// Shared types, constants and helpers of the slice axis normalizer
package slan_pkg;

  localparam int INDEX_WIDTH = 32;
  localparam int IDX_PAD     = 32 - INDEX_WIDTH;
  localparam int EXT_W       = 31;
  localparam int VAL_W       = 33;
  localparam int OFF_W       = 63;
  localparam int PROD_W      = 64;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_FULL  = 3'd0;
  localparam logic [2:0] KIND_INDEX = 3'd1;
  localparam logic [2:0] KIND_RANGE = 3'd2;
  localparam logic [2:0] KIND_STEP  = 3'd3;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OOB  = 2'd1,
    ERR_KIND = 2'd2,
    ERR_STEP = 2'd3
  } slan_err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } slan_state_e;

  // One classified axis, clamped bounds ready for the length divide
  typedef struct packed {
    logic signed [VAL_W-1:0] st;
    logic signed [VAL_W-1:0] en;
    logic signed [31:0]      sp;
    logic [EXT_W-1:0]        stride;
    slan_err_e               err;
    logic                    last;
  } slan_work_t;

  // Read the low INDEX_WIDTH bits as two's complement
  function automatic logic signed [31:0] sext_idx(input logic [31:0] v);
    sext_idx = $signed(v << IDX_PAD) >>> IDX_PAD;
  endfunction

endpackage

// ===== src/slice_axis_normalizer.sv =====
// Slice axis normalizer top level: front end, work queue and back end.
// The back end takes one item at a time and takes no new item until its result
// has transferred; its length divide uses a 32-step radix-2 divider. The front end
// and queue keep taking up to four items meanwhile.
// Reset (rst_ni low, asynchronous) empties the front end, the queue and the back
// end and clears the running offset accumulator to zero.
module slice_axis_normalizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [30:0]         axis_extent_i,
  input  logic [30:0]         axis_stride_i,
  input  logic [2:0]          spec_kind_i,
  input  logic signed [31:0]  start_value_i,
  input  logic                start_given_i,
  input  logic signed [31:0]  end_value_i,
  input  logic                end_given_i,
  input  logic signed [31:0]  step_value_i,
  input  logic                step_given_i,
  input  logic                last_axis_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  norm_start_o,
  output logic signed [31:0]  norm_end_o,
  output logic signed [31:0]  norm_step_o,
  output logic [30:0]         slice_length_o,
  output logic signed [62:0]  base_offset_o,
  output logic [1:0]          error_code_o,
  output logic                last_out_o
);

  // Front end to queue
  logic                 push_valid, push_ready;
  slan_pkg::slan_work_t push_data;

  // Queue to back end
  logic                 pop_valid, pop_ready;
  slan_pkg::slan_work_t pop_data;

  // Resolve negative and omitted bounds, clamp them and tag errors. Two register
  // stages: the first holds the raw transfer, the second the resolved bounds.
  slan_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .axis_extent_i (axis_extent_i),
    .axis_stride_i (axis_stride_i),
    .spec_kind_i   (spec_kind_i),
    .start_value_i (start_value_i),
    .start_given_i (start_given_i),
    .end_value_i   (end_value_i),
    .end_given_i   (end_given_i),
    .step_value_i  (step_value_i),
    .step_given_i  (step_given_i),
    .last_axis_i   (last_axis_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // Decouple the front end from the long-running divide so new axes keep
  // arriving while a result waits downstream.
  slan_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Divide for the slice length, multiply start by stride, accumulate the
  // saturating base offset and hold the result until its transfer. The
  // accumulator clears after the axis marked last, errored or not.
  slan_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .norm_start_o   (norm_start_o),
    .norm_end_o     (norm_end_o),
    .norm_step_o    (norm_step_o),
    .slice_length_o (slice_length_o),
    .base_offset_o  (base_offset_o),
    .error_code_o   (error_code_o),
    .last_out_o     (last_out_o)
  );

endmodule

// ===== src/slan_front.sv =====
// Front end: accept axis items, resolve and clamp bounds, classify errors
module slan_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [30:0]              axis_extent_i,
  input  logic [30:0]              axis_stride_i,
  input  logic [2:0]               spec_kind_i,
  input  logic signed [31:0]       start_value_i,
  input  logic                     start_given_i,
  input  logic signed [31:0]       end_value_i,
  input  logic                     end_given_i,
  input  logic signed [31:0]       step_value_i,
  input  logic                     step_given_i,
  input  logic                     last_axis_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output slan_pkg::slan_work_t     push_data_o
);

  localparam logic signed [slan_pkg::VAL_W-1:0] ZERO_V    = '0;
  localparam logic signed [slan_pkg::VAL_W-1:0] ONE_V     = slan_pkg::VAL_W'(1);
  localparam logic signed [slan_pkg::VAL_W-1:0] NEG_ONE_V = '1;

  // Raw input register
  logic                            raw_valid_q;
  logic [slan_pkg::EXT_W-1:0]      ext_q, stride_q;
  logic [2:0]                      kind_q;
  logic [31:0]                     sv_q, ev_q, pv_q;
  logic                            sg_q, eg_q, pg_q, last_q;

  // Resolved-bound register
  logic                            mid_valid_q;
  logic                            mid_index_q;
  logic signed [slan_pkg::VAL_W-1:0] mid_st_q, mid_en_q, mid_lo_q, mid_hi_q;
  logic signed [31:0]              mid_sp_q;
  logic [slan_pkg::EXT_W-1:0]      mid_stride_q;
  slan_pkg::slan_err_e             mid_err_q;
  logic                            mid_last_q;

  logic                            mid_free;

  // Resolve stage
  logic signed [slan_pkg::VAL_W-1:0] ext_v, ext_m1, sv_w, ev_w, sv_adj, ev_adj;
  logic signed [slan_pkg::VAL_W-1:0] st_a, en_a, lo_a, hi_a;
  logic signed [31:0]              sv_s, ev_s, pv_s, sp_a;
  logic                            neg_a;
  slan_pkg::slan_err_e             err_a;

  // Clamp stage
  logic signed [slan_pkg::VAL_W-1:0] st_b, en_b, st_c, en_c;
  slan_pkg::slan_err_e             err_b;

  assign mid_free     = !mid_valid_q || push_ready_i;
  assign in_ready_o   = !raw_valid_q || mid_free;
  assign push_valid_o = mid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
      mid_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) raw_valid_q <= in_valid_i;
      if (mid_free)   mid_valid_q <= raw_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ext_q    <= axis_extent_i;
      stride_q <= axis_stride_i;
      kind_q   <= spec_kind_i;
      sv_q     <= start_value_i;
      sg_q     <= start_given_i;
      ev_q     <= end_value_i;
      eg_q     <= end_given_i;
      pv_q     <= step_value_i;
      pg_q     <= step_given_i;
      last_q   <= last_axis_i;
    end
  end

  always_comb begin
    ext_v  = $signed({{(slan_pkg::VAL_W-slan_pkg::EXT_W){1'b0}}, ext_q});
    ext_m1 = ext_v - ONE_V;
    sv_s   = slan_pkg::sext_idx(sv_q);
    ev_s   = slan_pkg::sext_idx(ev_q);
    pv_s   = slan_pkg::sext_idx(pv_q);
    sv_w   = slan_pkg::VAL_W'(sv_s);
    ev_w   = slan_pkg::VAL_W'(ev_s);
    // Negative bounds count from the end of the axis
    sv_adj = sv_s[31] ? sv_w + ext_v : sv_w;
    ev_adj = ev_s[31] ? ev_w + ext_v : ev_w;
    sp_a   = (kind_q == slan_pkg::KIND_STEP && pg_q) ? pv_s : 32'sd1;
    neg_a  = sp_a[31];
    lo_a   = neg_a ? NEG_ONE_V : ZERO_V;
    hi_a   = neg_a ? ext_m1 : ext_v;

    unique case (kind_q)
      slan_pkg::KIND_FULL: begin
        st_a = ZERO_V;
        en_a = ext_v;
      end
      slan_pkg::KIND_INDEX: begin
        st_a = sv_adj;
        en_a = ZERO_V;
      end
      slan_pkg::KIND_RANGE, slan_pkg::KIND_STEP: begin
        st_a = sg_q ? sv_adj : (neg_a ? ext_m1 : ZERO_V);
        en_a = eg_q ? ev_adj : (neg_a ? NEG_ONE_V : ext_v);
      end
      default: begin
        st_a = ZERO_V;
        en_a = ZERO_V;
      end
    endcase

    priority if (kind_q[2]) err_a = slan_pkg::ERR_KIND;
    else if (sp_a == 32'sd0) err_a = slan_pkg::ERR_STEP;
    else                     err_a = slan_pkg::ERR_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (mid_free && raw_valid_q) begin
      mid_index_q  <= (kind_q == slan_pkg::KIND_INDEX);
      mid_st_q     <= st_a;
      mid_en_q     <= en_a;
      mid_lo_q     <= lo_a;
      mid_hi_q     <= hi_a;
      mid_sp_q     <= sp_a;
      mid_stride_q <= stride_q;
      mid_err_q    <= err_a;
      mid_last_q   <= last_q;
    end
  end

  always_comb begin
    priority if (mid_st_q < mid_lo_q) st_c = mid_lo_q;
    else if (mid_st_q > mid_hi_q)     st_c = mid_hi_q;
    else                              st_c = mid_st_q;
    priority if (mid_en_q < mid_lo_q) en_c = mid_lo_q;
    else if (mid_en_q > mid_hi_q)     en_c = mid_hi_q;
    else                              en_c = mid_en_q;

    // A single index selects one element and must lie inside the axis
    if (mid_index_q) begin
      st_b  = mid_st_q;
      en_b  = mid_st_q + ONE_V;
      err_b = (mid_st_q < ZERO_V || mid_st_q >= mid_hi_q) ? slan_pkg::ERR_OOB : mid_err_q;
    end else begin
      st_b  = st_c;
      en_b  = en_c;
      err_b = mid_err_q;
    end

    push_data_o.st     = st_b;
    push_data_o.en     = en_b;
    push_data_o.sp     = mid_sp_q;
    push_data_o.stride = mid_stride_q;
    push_data_o.err    = err_b;
    push_data_o.last   = mid_last_q;
  end

endmodule

// ===== src/slan_fifo.sv =====
// Short queue between the front end and the back end
module slan_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  slan_pkg::slan_work_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output slan_pkg::slan_work_t pop_data_o
);

  slan_pkg::slan_work_t            mem_q [slan_pkg::QUEUE_DEPTH];
  logic [slan_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [slan_pkg::QCNT_W-1:0]     count_q;
  logic                            push, pop;

  assign push_ready_o = (count_q != slan_pkg::QCNT_W'(slan_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [slan_pkg::QPTR_W-1:0] ptr_inc(input logic [slan_pkg::QPTR_W-1:0] p);
    ptr_inc = (p == slan_pkg::QPTR_W'(slan_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== src/slan_back.sv =====
// Back end: ceiling divide for the length, offset accumulate, result register
module slan_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  slan_pkg::slan_work_t pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   norm_start_o,
  output logic signed [31:0]   norm_end_o,
  output logic signed [31:0]   norm_step_o,
  output logic [30:0]          slice_length_o,
  output logic signed [62:0]   base_offset_o,
  output logic [1:0]           error_code_o,
  output logic                 last_out_o
);

  localparam int VW = slan_pkg::VAL_W;
  localparam int OW = slan_pkg::OFF_W;
  localparam logic signed [OW-1:0] OFF_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OFF_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic ready;
    logic prep;
    logic div;
    logic acc;
    logic out_valid;
  } slan_ctrl_t;

  slan_pkg::slan_state_e              state_q, state_d;
  slan_ctrl_t                         ctrl;

  logic signed [VW-1:0]               st_q, en_q;
  logic signed [31:0]                 sp_q;
  logic [slan_pkg::EXT_W-1:0]         stride_q;
  slan_pkg::slan_err_e                err_q;
  logic                               last_q;

  logic [31:0]                        quo_q, rem_q, ns_q;
  logic                               empty_q;
  logic [slan_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic signed [slan_pkg::PROD_W-1:0] prod_q;
  logic signed [OW-1:0]               acc_q;

  logic signed [31:0]                 norm_start_q, norm_end_q, norm_step_q;
  logic [30:0]                        len_q;
  logic signed [OW-1:0]               base_q;
  logic [1:0]                         err_out_q;
  logic                               last_out_q;

  logic                               neg, load, div_last, ge;
  logic signed [VW-1:0]               num_v;
  logic [31:0]                        ns_v;
  logic signed [VW+slan_pkg::EXT_W:0] prod_v;
  logic [32:0]                        rem_sh;
  logic [33:0]                        sub_v;
  logic signed [slan_pkg::PROD_W-1:0] sum_v;
  logic signed [OW-1:0]               sat_v, acc_new;

  assign div_last = (cnt_q == slan_pkg::DIV_CNT_W'(slan_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slan_pkg::ST_IDLE: if (pop_valid_i) state_d = slan_pkg::ST_PREP;
      slan_pkg::ST_PREP: begin
        state_d = (err_q != slan_pkg::ERR_NONE) ? slan_pkg::ST_ACC : slan_pkg::ST_DIV;
      end
      slan_pkg::ST_DIV:  if (div_last) state_d = slan_pkg::ST_ACC;
      slan_pkg::ST_ACC:  state_d = slan_pkg::ST_OUT;
      slan_pkg::ST_OUT:  if (out_ready_i) state_d = slan_pkg::ST_IDLE;
      default:           state_d = slan_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      slan_pkg::ST_IDLE: ctrl.ready     = 1'b1;
      slan_pkg::ST_PREP: ctrl.prep      = 1'b1;
      slan_pkg::ST_DIV:  ctrl.div       = 1'b1;
      slan_pkg::ST_ACC:  ctrl.acc       = 1'b1;
      slan_pkg::ST_OUT:  ctrl.out_valid = 1'b1;
      default:           ctrl           = '0;
    endcase
  end

  assign pop_ready_o = ctrl.ready;
  assign out_valid_o = ctrl.out_valid;
  assign load        = ctrl.ready && pop_valid_i;

  always_comb begin
    neg    = sp_q[31];
    // ceil(d / n) = floor((d - 1) / n) + 1 for d > 0; x + ~y = x - y - 1
    num_v  = neg ? st_q + ~en_q : en_q + ~st_q;
    ns_v   = neg ? (~sp_q + 32'd1) : sp_q;
    prod_v = st_q * $signed({1'b0, stride_q});
    rem_sh = {rem_q, quo_q[31]};
    sub_v  = {1'b0, rem_sh} - {2'b00, ns_q};
    ge     = !sub_v[33];
    sum_v  = {acc_q[OW-1], acc_q} + prod_q;
    if (sum_v[slan_pkg::PROD_W-1] != sum_v[slan_pkg::PROD_W-2]) begin
      sat_v = sum_v[slan_pkg::PROD_W-1] ? OFF_MIN : OFF_MAX;
    end else begin
      sat_v = sum_v[OW-1:0];
    end
    acc_new = (err_q != slan_pkg::ERR_NONE) ? acc_q : sat_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slan_pkg::ST_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.prep) cnt_q <= '0;
      else if (ctrl.div) cnt_q <= cnt_q + 1'b1;
      if (ctrl.acc) acc_q <= last_q ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      st_q     <= pop_data_i.st;
      en_q     <= pop_data_i.en;
      sp_q     <= pop_data_i.sp;
      stride_q <= pop_data_i.stride;
      err_q    <= pop_data_i.err;
      last_q   <= pop_data_i.last;
    end
    if (ctrl.prep) begin
      quo_q   <= num_v[31:0];
      empty_q <= num_v[VW-1];
      rem_q   <= '0;
      ns_q    <= ns_v;
      prod_q  <= slan_pkg::PROD_W'(prod_v);
    end
    if (ctrl.div) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? sub_v[31:0] : rem_sh[31:0];
    end
    if (ctrl.acc) begin
      base_q     <= acc_new;
      err_out_q  <= err_q;
      last_out_q <= last_q;
      if (err_q != slan_pkg::ERR_NONE) begin
        norm_start_q <= '0;
        norm_end_q   <= '0;
        norm_step_q  <= '0;
        len_q        <= '0;
      end else begin
        norm_start_q <= st_q[31:0];
        norm_end_q   <= en_q[31:0];
        norm_step_q  <= sp_q;
        len_q        <= empty_q ? '0 : 31'(quo_q + 32'd1);
      end
    end
  end

  assign norm_start_o   = norm_start_q;
  assign norm_end_o     = norm_end_q;
  assign norm_step_o    = norm_step_q;
  assign slice_length_o = len_q;
  assign base_offset_o  = base_q;
  assign error_code_o   = err_out_q;
  assign last_out_o     = last_out_q;

endmodule

// ===== src/slan_checker.sv =====
// Port-level checks of the slice axis normalizer and their bind
`include "slice_axis_normalizer_assert.svh"

module slan_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [30:0]         axis_extent_i,
  input logic [30:0]         axis_stride_i,
  input logic [2:0]          spec_kind_i,
  input logic signed [31:0]  start_value_i,
  input logic                start_given_i,
  input logic signed [31:0]  end_value_i,
  input logic                end_given_i,
  input logic signed [31:0]  step_value_i,
  input logic                step_given_i,
  input logic                last_axis_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [31:0]  norm_start_o,
  input logic signed [31:0]  norm_end_o,
  input logic signed [31:0]  norm_step_o,
  input logic [30:0]         slice_length_o,
  input logic signed [62:0]  base_offset_o,
  input logic [1:0]          error_code_o,
  input logic                last_out_o
);

  logic out_ok, out_err;

  assign out_ok  = out_valid_o && (error_code_o == slan_pkg::ERR_NONE);
  assign out_err = out_valid_o && (error_code_o != slan_pkg::ERR_NONE);

  // Hold a stalled result
  `SLAN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(base_offset_o) && $stable(slice_length_o) && $stable(last_out_o), "stalled result changed")

  // Drop all geometry on an errored axis
  `SLAN_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_err, (norm_start_o == 32'sd0) && (norm_end_o == 32'sd0) && (norm_step_o == 32'sd0) && (slice_length_o == 31'd0), "errored axis has nonzero geometry")

  // A good axis never reports a zero step
  `SLAN_ASSERT_IMP(a_step_nonzero, clk_i, rst_ni, out_ok, norm_step_o != 32'sd0, "good axis with zero step")

  // Unit step: the length is the bound difference
  `SLAN_ASSERT_IMP(a_unit_len, clk_i, rst_ni, out_ok && (norm_step_o == 32'sd1) && (norm_end_o > norm_start_o), slice_length_o == 31'(norm_end_o - norm_start_o), "unit-step length mismatch")

endmodule

bind slice_axis_normalizer slan_checker u_slan_checker (.*);
